FILE: rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int OP_W      = 3;
  localparam int OPERAND_W = 32;
  localparam int RESULT_W  = 32;
  localparam int EXT_W     = 64;  // widest internal data word
  localparam int MUL_DIGIT = 8;   // multiplier bits retired per cycle

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // latch the incoming token
    logic    push;      // push latched operand
    logic    fetch;     // read entry below top of stack
    logic    pop_alu;   // replace two entries by add/sub result
    logic    md_start;  // start multiply or divide
    logic    pop_md;    // replace two entries by mul/div result
    logic    set_err;
    status_t err_code;
    logic    emit;      // load output register, clear stack
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            err_set;
    logic            depth_zero;
    logic            depth_full;
    logic            depth_lt2;
    logic            divisor_zero;
    logic            md_done;
    logic            out_busy;
  } stat_t;

endpackage

FILE: rtl/rpn_token_if.sv
interface rpn_token_if;
  logic                                 valid;
  logic                                 ready;
  logic [rpn_pkg::OP_W-1:0]             operation;
  logic signed [rpn_pkg::OPERAND_W-1:0] operand;
  logic                                 last_token;

  modport source(output valid, operation, operand, last_token, input ready);
  modport sink(input valid, operation, operand, last_token, output ready);
endinterface

FILE: rtl/rpn_result_if.sv
interface rpn_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpn_pkg::RESULT_W-1:0] result;
  logic [1:0]                          status;

  modport source(output valid, result, status, input ready);
  modport sink(input valid, result, status, output ready);
endinterface

FILE: rtl/rpn_stack_evaluator.sv
// Push, undefined opcode, underflow or a token after an error end at decode;
// add/subtract and divide by zero also fetch the entry below; multiply
// and divide run the shared iterative unit, retiring 8 or 1 bits per cycle.
// A last token then emits, held while an earlier result waits unaccepted;
// the result transaction shows the next cycle. Sync reset (rst) empties the
// stack, clears the error and drops any pending result; memory is not cleared.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input logic          clk,
  input logic          rst,
  rpn_token_if.sink    tokens,
  rpn_result_if.source results
);

  // Controller walks each token through decode, operand fetch from the
  // stack memory and, for multiply/divide, the iterative unit. The
  // datapath keeps top of stack in a register so only one memory read
  // (the entry beneath) is needed per operator.
  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t stat;
  logic           token_ready;

  assign tokens.ready = token_ready;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .token_valid(tokens.valid),
    .token_ready(token_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Output register decouples the result transaction from token intake;
  // the sequencer only waits on it when a second result is ready.
  rpn_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (tokens.operation),
    .operand   (tokens.operand),
    .last_token(tokens.last_token),
    .results   (results)
  );

`ifndef SYNTH
  // one token in flight at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.ready |=> !tokens.ready)
    else $error("token accepted while previous one still in work");

  // a result clears the expression state
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> stat.depth_zero && !stat.err_set)
    else $error("stack or error not cleared after result");

  // controller never pushes onto a full stack
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.depth_full && !stat.err_set)
    else $error("push onto full stack or after error");

  // error results carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.status != rpn_pkg::ST_OK) |-> results.result == '0)
    else $error("nonzero result with error status");
`endif

endmodule

FILE: rtl/rpn_muldiv.sv
// Shared iterative unit: radix-256 multiply or restoring signed divide.
module rpn_muldiv #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  is_div,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] q
);

  localparam int MUL_STEPS = (DATA_WIDTH + rpn_pkg::MUL_DIGIT - 1) / rpn_pkg::MUL_DIGIT;
  localparam int CNT_W     = $clog2(DATA_WIDTH + 1);
  localparam int PP_W      = DATA_WIDTH + rpn_pkg::MUL_DIGIT;

  // r_a: accumulator / remainder, r_b: multiplicand / divisor,
  // r_c: multiplier / quotient
  logic [DATA_WIDTH-1:0] r_a, r_b, r_c;
  logic                  div_q, neg;
  logic                  busy;
  logic [CNT_W-1:0]      cnt;

  logic [DATA_WIDTH-1:0] abs_a, abs_b;
  logic [PP_W-1:0]       pp;
  logic [DATA_WIDTH:0]   trial, diff;
  logic                  fits;

  assign abs_a = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
  assign abs_b = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;

  assign pp    = PP_W'(r_b) * PP_W'(r_c[rpn_pkg::MUL_DIGIT-1:0]);
  assign trial = {r_a, r_c[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, r_b};
  assign fits  = trial >= {1'b0, r_b};

  assign done = busy && (cnt == '0);
  assign q    = div_q ? (neg ? (~r_c + DATA_WIDTH'(1)) : r_c) : r_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= is_div ? CNT_W'(DATA_WIDTH) : CNT_W'(MUL_STEPS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_q <= is_div;
      neg   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      r_a   <= '0;
      r_b   <= is_div ? abs_b : a;
      r_c   <= is_div ? abs_a : b;
    end else if (busy && (cnt != '0)) begin
      if (div_q) begin
        r_a <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        r_c <= {r_c[DATA_WIDTH-2:0], fits};
      end else begin
        r_a <= r_a + pp[DATA_WIDTH-1:0];
        r_b <= r_b << rpn_pkg::MUL_DIGIT;
        r_c <= r_c >> rpn_pkg::MUL_DIGIT;
      end
    end
  end

endmodule

FILE: rtl/rpn_dp.sv
// Stack datapath: top of stack in a register, the rest in a memory.
module rpn_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rpn_pkg::cmd_t                        cmd,
  output rpn_pkg::stat_t                       stat,
  input  logic [rpn_pkg::OP_W-1:0]             operation,
  input  logic signed [rpn_pkg::OPERAND_W-1:0] operand,
  input  logic                                 last_token,
  rpn_result_if.source                         results
);

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  logic [DATA_WIDTH-1:0]        mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]        tos, below, opnd_q;
  logic [rpn_pkg::OP_W-1:0]     op_q;
  logic                         last_q;
  logic [DEPTH_W-1:0]           depth;
  rpn_pkg::status_t             err;
  logic                         out_valid;
  logic [rpn_pkg::RESULT_W-1:0] out_result;
  rpn_pkg::status_t             out_status;

  logic signed [rpn_pkg::EXT_W-1:0] opnd_ext, tos_ext;
  logic signed [DATA_WIDTH-1:0]     tos_s;
  logic [DEPTH_W-1:0]               top_idx, below_idx;
  logic [DATA_WIDTH-1:0]            alu_res, md_q;
  logic                             md_done;

  assign opnd_ext  = rpn_pkg::EXT_W'(operand);
  assign tos_s     = tos;
  assign tos_ext   = rpn_pkg::EXT_W'(tos_s);
  assign top_idx   = depth - DEPTH_W'(1);
  assign below_idx = depth - DEPTH_W'(2);
  assign alu_res   = (op_q == rpn_pkg::OP_SUB) ? (below - tos) : (below + tos);

  rpn_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .is_div(op_q == rpn_pkg::OP_DIV),
    .a     (below),
    .b     (tos),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      err       <= rpn_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        depth <= '0;
      end else if (cmd.push) begin
        depth <= depth + DEPTH_W'(1);
      end else if (cmd.pop_alu || cmd.pop_md) begin
        depth <= depth - DEPTH_W'(1);
      end
      if (cmd.emit) begin
        err <= rpn_pkg::ST_OK;
      end else if (cmd.set_err) begin
        err <= cmd.err_code;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      last_q <= last_token;
      opnd_q <= opnd_ext[DATA_WIDTH-1:0];
    end
    if (cmd.push) begin
      tos <= opnd_q;
    end else if (cmd.pop_alu) begin
      tos <= alu_res;
    end else if (cmd.pop_md) begin
      tos <= md_q;
    end
    if (cmd.emit) begin
      out_status <= (err != rpn_pkg::ST_OK) ? err :
                    ((depth == '0) ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_OK);
      out_result <= ((err == rpn_pkg::ST_OK) && (depth != '0)) ?
                    tos_ext[rpn_pkg::RESULT_W-1:0] : '0;
    end
  end

  // old top spills into the memory on a push
  always_ff @(posedge clk) begin
    if (cmd.push && (depth != '0)) begin
      mem[top_idx[ADDR_W-1:0]] <= tos;
    end
    if (cmd.fetch) begin
      below <= mem[below_idx[ADDR_W-1:0]];
    end
  end

  assign results.valid  = out_valid;
  assign results.result = out_result;
  assign results.status = out_status;

  assign stat.op           = op_q;
  assign stat.last         = last_q;
  assign stat.err_set      = err != rpn_pkg::ST_OK;
  assign stat.depth_zero   = depth == '0;
  assign stat.depth_full   = depth == DEPTH_W'(STACK_DEPTH);
  assign stat.depth_lt2    = depth < DEPTH_W'(2);
  assign stat.divisor_zero = tos == '0;
  assign stat.md_done      = md_done;
  assign stat.out_busy     = out_valid && !results.ready;

endmodule

FILE: rtl/rpn_ctrl.sv
// Token sequencer: one token at a time.
module rpn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           token_valid,
  output logic           token_ready,
  input  rpn_pkg::stat_t stat,
  output rpn_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_OPER,
    S_MD,
    S_EMIT
  } state_t;

  state_t state, state_next, state_done;

  assign token_ready = state == S_IDLE;
  assign state_done  = stat.last ? S_EMIT : S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (token_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = state_done;
        if (!stat.err_set) begin
          unique case (stat.op)
            rpn_pkg::OP_PUSH: begin
              if (stat.depth_full) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = rpn_pkg::ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
              if (stat.depth_lt2) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = rpn_pkg::ST_UNDERFLOW;
              end else begin
                cmd.fetch  = 1'b1;
                state_next = S_OPER;
              end
            end
            default: ;  // undefined opcode: no effect
          endcase
        end
      end
      S_OPER: begin
        state_next = state_done;
        unique case (stat.op)
          rpn_pkg::OP_MUL: begin
            cmd.md_start = 1'b1;
            state_next   = S_MD;
          end
          rpn_pkg::OP_DIV: begin
            if (stat.divisor_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = rpn_pkg::ST_DIV_ZERO;
            end else begin
              cmd.md_start = 1'b1;
              state_next   = S_MD;
            end
          end
          default: cmd.pop_alu = 1'b1;  // add or subtract
        endcase
      end
      S_MD: begin
        if (stat.md_done) begin
          cmd.pop_md = 1'b1;
          state_next = state_done;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: tb/sv/rpn_stack_evaluator_test.sv
module rpn_stack_evaluator_test;
  import rpn_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = CLK_PERIOD - CLK_HIGH;
  localparam int RESET_CYCLES   = 5;
  localparam int TB_STACK_DEPTH = 64;
  localparam int TB_DATA_WIDTH  = 32;
  localparam int ITEM_TARGET    = 1550;
  localparam int HOLDOFF_CYCLES = 400;   // long receiver stall so the block backs up
  localparam int DRAIN_CYCLES   = 64;    // longer than a divide plus the emit step
  localparam int TIMEOUT_CYCLES = 500000;

  // Opcodes 5..7 are undefined; the block treats them as no-ops.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic signed [OPERAND_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [OPERAND_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [OP_W-1:0]             op;
    logic signed [OPERAND_W-1:0] operand;
    logic                        last;
  } token_t;

  typedef struct {
    logic signed [RESULT_W-1:0] result;
    status_t                    status;
  } outcome_t;

  // Tracks the evaluator's stack and sticky error, and holds the outcome
  // each finished expression should produce, oldest first.
  class expression_scoreboard;
    logic signed [TB_DATA_WIDTH-1:0] stack_model [TB_STACK_DEPTH];
    int unsigned                     depth;
    status_t                         sticky_err;
    outcome_t                        expected_results [$];
    int                              failures;

    function new();
      depth      = 0;
      sticky_err = ST_OK;
      failures   = 0;
    endfunction

    // Applies one accepted token; a token marked last queues an outcome.
    function void note_token(logic [OP_W-1:0] op, logic signed [OPERAND_W-1:0] operand,
                             logic last);
      logic signed [TB_DATA_WIDTH-1:0] lhs;
      logic signed [TB_DATA_WIDTH-1:0] rhs;
      logic signed [TB_DATA_WIDTH-1:0] acc;
      longint                          quot;
      outcome_t                        out;
      if (sticky_err == ST_OK) begin
        if (op == OP_PUSH) begin
          if (depth >= TB_STACK_DEPTH) begin
            sticky_err = ST_OVERFLOW;
          end else begin
            stack_model[depth] = operand;
            depth++;
          end
        end else if (op <= OP_DIV) begin
          if (depth < 2) begin
            sticky_err = ST_UNDERFLOW;
          end else begin
            rhs = stack_model[depth-1];
            lhs = stack_model[depth-2];
            if (op == OP_DIV && rhs == 0) begin
              sticky_err = ST_DIV_ZERO;
            end else begin
              case (op)
                OP_ADD: acc = lhs + rhs;
                OP_SUB: acc = lhs - rhs;
                OP_MUL: acc = lhs * rhs;
                default: begin
                  // 64-bit divide: most negative / -1 wraps back on truncation
                  quot = longint'(lhs) / longint'(rhs);
                  acc  = quot[TB_DATA_WIDTH-1:0];
                end
              endcase
              depth--;
              stack_model[depth-1] = acc;
            end
          end
        end
      end
      if (last) begin
        out.status = sticky_err;
        out.result = '0;
        if (sticky_err == ST_OK) begin
          if (depth == 0) out.status = ST_UNDERFLOW;
          else out.result = stack_model[depth-1];
        end
        expected_results.push_back(out);
        depth      = 0;
        sticky_err = ST_OK;
      end
    endfunction

    function void check_result(logic signed [RESULT_W-1:0] result, logic [1:0] status);
      outcome_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, result %h status %0d",
                 $time, result, status);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, status);
        failures++;
      end
      if (result !== want.result) begin
        $display("%0t: result mismatch, expected %h actual %h",
                 $time, want.result, result);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rpn_token_if  tokens();
  rpn_result_if results();

  rpn_stack_evaluator #(
    .STACK_DEPTH(TB_STACK_DEPTH),
    .DATA_WIDTH (TB_DATA_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .tokens (tokens),
    .results(results)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  expression_scoreboard sb = new();

  // Idle rates in percent per cycle, set per phase by the stimulus.
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  // The stimulus bumps the request count; the receiver serves each one once.
  int holdoff_requested = 0;
  int holdoff_served    = 0;
  int items_sent        = 0;

  token_t expr [$];   // expression under construction

  // Both monitors sample pre-edge values, so ordering within the step is moot.
  always @(posedge clk) begin
    if (!rst && tokens.valid && tokens.ready)
      sb.note_token(tokens.operation, tokens.operand, tokens.last_token);
    if (!rst && results.valid && results.ready)
      sb.check_result(results.result, results.status);
  end

  // Receiver: random ready, or a long hold-off counted here when requested.
  initial begin : receiver
    int quiet;
    quiet = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_requested != holdoff_served) begin
        holdoff_served = holdoff_requested;
        quiet          = HOLDOFF_CYCLES;
      end
      if (quiet > 0) begin
        quiet--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Operand mix: extremes, zero and small values (so divides hit zero and
  // exact quotients), and full-width random values.
  function automatic logic signed [OPERAND_W-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_MAX;
      2:       return VAL_MIN;
      3:       return -1;
      4, 5:    return $signed($urandom_range(40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_token(logic [OP_W-1:0] op, logic signed [OPERAND_W-1:0] v);
    token_t t;
    t.op      = op;
    t.operand = v;
    t.last    = 1'b0;
    expr.push_back(t);
  endfunction

  // Random operator among add, subtract, multiply and divide.
  function automatic logic [OP_W-1:0] pick_operator();
    return OP_W'(OP_ADD + $urandom_range(3));
  endfunction

  // One token transaction. Valid stays up across back-to-back tokens, so
  // each time step sees at most one assignment to it.
  task automatic send_token(input token_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      tokens.valid <= 1'b0;
      @(posedge clk);
    end
    tokens.valid      <= 1'b1;
    tokens.operation  <= t.op;
    tokens.operand    <= t.operand;
    tokens.last_token <= t.last;
    @(posedge clk);
    while (!tokens.ready) @(posedge clk);
    items_sent++;
  endtask

  // Sends the built expression, marking its final token as last.
  task automatic flush_expression();
    token_t t;
    for (int i = 0; i < expr.size(); i++) begin
      t      = expr[i];
      t.last = (i == expr.size() - 1);
      send_token(t);
    end
    expr.delete();
  endtask

  // Pushes the given number of operands (near, at or past the stack depth), then a few operators.
  task automatic send_deep(input int pushes);
    repeat (pushes) add_token(OP_PUSH, pick_operand());
    repeat ($urandom_range(3, 1)) add_token(pick_operator(), $urandom);
    flush_expression();
  endtask

  // Mostly well-formed expressions with random content; some are noise,
  // some end with a stray operator, a few run the stack near or past full.
  task automatic send_random_expression();
    int kind;
    int n;
    int level;
    int pushed;
    int target;
    kind = $urandom_range(99);
    if (kind < 2) begin
      send_deep($urandom_range(66, 60));
    end else if (kind < 17) begin
      n = $urandom_range(6, 1);
      repeat (n) add_token(OP_W'($urandom_range(7)), $urandom);
      flush_expression();
    end else begin
      n      = (kind < 27) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      target = ($urandom_range(9) == 0) ? 2 : 1;   // sometimes leave extra entries
      level  = 0;
      pushed = 0;
      while (pushed < n || level > target) begin
        if ($urandom_range(19) == 0)
          add_token(OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO)), $urandom);
        if (pushed < n && (level < 2 || $urandom_range(1) == 1)) begin
          add_token(OP_PUSH, pick_operand());
          pushed++;
          level++;
        end else begin
          add_token(pick_operator(), $urandom);
          level--;
        end
      end
      if ($urandom_range(19) == 0) add_token(pick_operator(), $urandom);
      flush_expression();
    end
  endtask

  initial begin : stimulus
    tokens.valid      <= 1'b0;
    tokens.operation  <= OP_PUSH;
    tokens.operand    <= '0;
    tokens.last_token <= 1'b0;
    rst               <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      // sender mostly busy / receiver mostly stalled, then swapped, then full rate
      case (phase)
        0:       begin sender_idle_pct = 12; receiver_idle_pct = 84; end
        1:       begin sender_idle_pct = 84; receiver_idle_pct = 12; end
        default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
      endcase

      if (phase == 0) begin
        // add wrapping past the most positive value
        add_token(OP_PUSH, VAL_MAX); add_token(OP_PUSH, 1); add_token(OP_ADD, 0);
        flush_expression();
        // most negative divided by minus one wraps
        add_token(OP_PUSH, VAL_MIN); add_token(OP_PUSH, -1); add_token(OP_DIV, 0);
        flush_expression();
        // divide by zero, then a token after the error is ignored
        add_token(OP_PUSH, 7); add_token(OP_PUSH, 0); add_token(OP_DIV, 0);
        add_token(OP_PUSH, 5);
        flush_expression();
        // negative quotient truncates toward zero
        add_token(OP_PUSH, -7); add_token(OP_PUSH, 2); add_token(OP_DIV, VAL_MIN);
        flush_expression();
        // multiply and subtract
        add_token(OP_PUSH, 6); add_token(OP_PUSH, -7); add_token(OP_MUL, VAL_MAX);
        add_token(OP_PUSH, 3); add_token(OP_SUB, -1);
        flush_expression();
        // operator on an empty stack
        add_token(OP_ADD, -1);
        flush_expression();
        // undefined opcode alone: empty stack at the last token
        add_token(OP_UNDEF_LO, 0);
        flush_expression();
        // undefined opcode as last with two entries left: top one reported
        add_token(OP_PUSH, 9); add_token(OP_PUSH, 4); add_token(OP_UNDEF_HI, VAL_MAX);
        flush_expression();
        add_token(OP_PUSH, 10); add_token(OP_PUSH, 3); add_token(OP_SUB, 0);
        flush_expression();
        // exactly full stack, then one push too many
        send_deep(TB_STACK_DEPTH);
        send_deep(TB_STACK_DEPTH + 1);
      end

      // full-rate phase: receiver stalls long, sender keeps offering tokens
      if (phase == 2) holdoff_requested++;

      while (items_sent < (phase + 1) * ITEM_TARGET / 3) send_random_expression();
    end
    tokens.valid <= 1'b0;

    // let the final expectation land, then drain
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0)
      $display("rpn_stack_evaluator_test passed");
    else
      $display("rpn_stack_evaluator_test failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("rpn_stack_evaluator_test failed");
    $finish;
  end

endmodule
